### hdl/ultrasonic_ping_ranger_defines.svh
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_PING_RANGER_DEFINES_SVH
`define ULTRASONIC_PING_RANGER_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define UPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upr assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define UPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upr assertion failed");

`endif

### hdl/upr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger package
// Widths, register codes, reset values, phase type, measurement struct and the
// inch divider constants shared by the ranger modules.
// ----------------------------------------------------------------------------
package upr_pkg;

  // Width of the echo wait and pulse width counters.
  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam int SINCE_W = 24;
  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  localparam int INTERVAL_W  = 24;
  localparam int THRESH_W    = 10;
  localparam int TRIG_W      = 8;
  localparam int TIMEOUT_W   = 20;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd100000;
  localparam logic [THRESH_W-1:0]   THRESH_RST   = 10'd1;
  localparam logic [TRIG_W-1:0]     TRIG_RST     = 8'd5;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST  = 20'd1000000;

  // Common compare width for the timeout check.
  localparam int TMO_CMP_W = (COUNT_BITS > TIMEOUT_W) ? COUNT_BITS : TIMEOUT_W;

  localparam int DIST_W = 13;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Inches = width / (74 us per inch * 2 for the round trip) = width / 148.
  // 148 = 4 * 37: drop two bits, then multiply by a rounded-up reciprocal
  // of 37. The reciprocal error stays below 37 < 64 = 2^6, which keeps the
  // quotient exact over the full counter range.
  localparam int US_PER_INCH   = 74;
  localparam int ROUND_TRIP    = 2;
  localparam int DIV_PRE_SHIFT = 2;
  localparam int DIV_ODD       = (US_PER_INCH * ROUND_TRIP) / (1 << DIV_PRE_SHIFT);
  localparam int DIV_X_W       = COUNT_BITS - DIV_PRE_SHIFT;
  localparam int DIV_SHIFT     = DIV_X_W + 6;
  localparam logic [63:0] DIV_MUL =
      ((64'd1 << DIV_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);
  localparam int DIV_PROD_W    = DIV_X_W + DIV_SHIFT - 4;
  localparam int QUOT_W        = DIV_PROD_W - DIV_SHIFT;
  localparam int QUOT_X_W      = (QUOT_W > DIST_W) ? QUOT_W : DIST_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PING_INTERVAL    = 2'd0,
    REG_CHANGE_THRESHOLD = 2'd1,
    REG_TRIGGER_WIDTH    = 2'd2,
    REG_ECHO_TIMEOUT     = 2'd3
  } upr_reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_WLOW  = 3'd2,
    PH_WHIGH = 3'd3,
    PH_MEAS  = 3'd4
  } upr_phase_t;

  // Measurement result handed from the controller to the range stage.
  typedef struct packed {
    logic                  finish;
    logic                  timed_out;
    logic [COUNT_BITS-1:0] width;
  } upr_meas_t;

endpackage
`default_nettype wire

### hdl/upr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger controller
// Ping interval counter, trigger pulse and echo wait / measure sequencer.
// ----------------------------------------------------------------------------
module upr_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            step,
  input  wire logic                            echo,
  input  wire logic [upr_pkg::INTERVAL_W-1:0]  ping_interval,
  input  wire logic [upr_pkg::TRIG_W-1:0]      trigger_width,
  input  wire logic [upr_pkg::TIMEOUT_W-1:0]   echo_timeout,
  output logic                                 trigger,
  output upr_pkg::upr_meas_t                   meas
);
  import upr_pkg::*;

  upr_phase_t            phase_r, phase_nxt;
  logic [SINCE_W-1:0]    since_r, since_nxt;
  logic [COUNT_BITS-1:0] wait_r, wait_nxt;
  logic [COUNT_BITS-1:0] pulse_r, pulse_nxt;

  logic [SINCE_W-1:0]    since_inc;
  logic [COUNT_BITS-1:0] wait_inc;
  logic [COUNT_BITS-1:0] pulse_inc;
  logic                  fire;
  logic                  trig_short;
  logic                  trig_done;
  logic                  meas_end;
  logic                  wait_tmo;

  assign since_inc  = (since_r == SINCE_MAX) ? SINCE_MAX : since_r + 1'b1;
  assign wait_inc   = (wait_r == COUNT_MAX) ? COUNT_MAX : wait_r + 1'b1;
  assign pulse_inc  = (pulse_r == COUNT_MAX) ? COUNT_MAX : pulse_r + 1'b1;
  assign fire       = since_inc > ping_interval;
  assign trig_short = trigger_width <= TRIG_W'(1);
  assign trig_done  = wait_inc >= COUNT_BITS'(trigger_width);
  assign meas_end   = (phase_r == PH_MEAS) && !echo;
  assign wait_tmo   = (TMO_CMP_W'(wait_inc) >= TMO_CMP_W'(echo_timeout)) ||
                      (wait_inc == COUNT_MAX);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (fire) phase_nxt = trig_short ? PH_WLOW : PH_TRIG;
      end
      PH_TRIG: begin
        if (trig_done) phase_nxt = PH_WLOW;
      end
      PH_WLOW: begin
        if (wait_tmo) phase_nxt = PH_IDLE;
        else if (!echo) phase_nxt = PH_WHIGH;
      end
      PH_WHIGH: begin
        if (wait_tmo) phase_nxt = PH_IDLE;
        else if (echo) phase_nxt = PH_MEAS;
      end
      PH_MEAS: begin
        if (!echo || wait_tmo) phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Counters and per-tick outputs
  always_comb begin
    since_nxt      = since_inc;
    wait_nxt       = wait_r;
    pulse_nxt      = pulse_r;
    trigger        = 1'b0;
    meas.finish    = 1'b0;
    meas.timed_out = 1'b0;
    meas.width     = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (fire) begin
          since_nxt = '0;
          trigger   = 1'b1;
          pulse_nxt = '0;
          wait_nxt  = trig_short ? '0 : COUNT_BITS'(1);
        end
      end
      PH_TRIG: begin
        trigger  = 1'b1;
        wait_nxt = trig_done ? '0 : wait_inc;
      end
      PH_WLOW, PH_WHIGH, PH_MEAS: begin
        if (meas_end) begin
          meas.finish = 1'b1;
          meas.width  = pulse_r;
          wait_nxt    = '0;
          pulse_nxt   = '0;
        end else begin
          if (phase_r == PH_WHIGH && echo) pulse_nxt = COUNT_BITS'(1);
          else if (phase_r == PH_MEAS) pulse_nxt = pulse_inc;
          wait_nxt = wait_inc;
          if (wait_tmo) begin
            meas.finish    = 1'b1;
            meas.timed_out = 1'b1;
            wait_nxt       = '0;
            pulse_nxt      = '0;
          end
        end
      end
      default: begin
        wait_nxt  = '0;
        pulse_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      since_r <= '0;
      wait_r  <= '0;
      pulse_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      since_r <= since_nxt;
      wait_r  <= wait_nxt;
      pulse_r <= pulse_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/upr_range.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger range stage
// Converts pulse width to inches and applies the change threshold.
// ----------------------------------------------------------------------------
module upr_range (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire upr_pkg::upr_meas_t            meas,
  input  wire logic [upr_pkg::THRESH_W-1:0]  threshold,
  output logic                               report,
  output logic [upr_pkg::DIST_W-1:0]         distance_nxt
);
  import upr_pkg::*;

  logic [DIST_W-1:0]     dist_r;
  logic [DIV_X_W-1:0]    div_x;
  logic [DIV_PROD_W-1:0] prod;
  logic [QUOT_X_W-1:0]   quot;
  logic [DIST_W-1:0]     inches;
  logic [DIST_W:0]       upper;
  logic [DIST_W:0]       lower;

  // width / 148 by shift and reciprocal multiply
  assign div_x  = meas.width[COUNT_BITS-1:DIV_PRE_SHIFT];
  assign prod   = DIV_PROD_W'(div_x) * DIV_MUL[DIV_PROD_W-1:0];
  assign quot   = QUOT_X_W'(prod >> DIV_SHIFT);
  assign inches = (quot > QUOT_X_W'(DIST_MAX)) ? DIST_MAX : quot[DIST_W-1:0];

  assign upper  = {1'b0, dist_r} + (DIST_W+1)'(threshold);
  assign lower  = {1'b0, inches} + (DIST_W+1)'(threshold);
  assign report = meas.finish && (({1'b0, inches} > upper) || (lower < {1'b0, dist_r}));
  assign distance_nxt = report ? inches : dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= '0;
    end else if (step) begin
      dist_r <= distance_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/ultrasonic_ping_ranger.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted word is held in the input register, then processed into the
// result register, where it is presented until taken.
// Throughput: one word per cycle; input and output registers advance together
// and stall only while a presented result word is held by out_stall.
// Reset (rst_n low, synchronous): phase idle, all counters and the stored
// distance zero, configuration registers back to their defaults, pipe empty.
// ----------------------------------------------------------------------------
// Ultrasonic ping ranger top level
// One word per microsecond tick: drives the trigger, times the echo pulse and
// reports distance in inches when it changes by more than the threshold.
// ----------------------------------------------------------------------------
`include "ultrasonic_ping_ranger_defines.svh"
module ultrasonic_ping_ranger (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_echo_level,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_trigger_level,
  output logic                                  out_reading_done,
  output logic                                  out_timed_out,
  output logic                                  out_report_valid,
  output logic [upr_pkg::DIST_W-1:0]            out_distance_in,
  input  wire logic                             cfg_we,
  input  wire logic [upr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [upr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import upr_pkg::*;

  // Configuration registers
  logic [INTERVAL_W-1:0] ping_interval_r;
  logic [THRESH_W-1:0]   threshold_r;
  logic [TRIG_W-1:0]     trig_width_r;
  logic [TIMEOUT_W-1:0]  timeout_r;

  // Input register
  logic s1_valid_r;
  logic s1_echo_r;

  // Result register
  logic              out_valid_r;
  logic              out_trig_r;
  logic              out_done_r;
  logic              out_tout_r;
  logic              out_rep_r;
  logic [DIST_W-1:0] out_dist_r;

  logic              advance;
  logic              step;
  logic              trigger;
  upr_meas_t         meas;
  logic              report;
  logic [DIST_W-1:0] distance_nxt;

  // The whole pipe moves unless a presented word is being held back.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  // The tick in the input register is processed as it moves to the output.
  assign step     = advance && s1_valid_r;

  // Register writes; the four registers cover every index, so the case default is never reached.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_interval_r <= INTERVAL_RST;
      threshold_r     <= THRESH_RST;
      trig_width_r    <= TRIG_RST;
      timeout_r       <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PING_INTERVAL:    ping_interval_r <= cfg_wdata[INTERVAL_W-1:0];
        REG_CHANGE_THRESHOLD: threshold_r     <= cfg_wdata[THRESH_W-1:0];
        REG_TRIGGER_WIDTH:    trig_width_r    <= cfg_wdata[TRIG_W-1:0];
        REG_ECHO_TIMEOUT:     timeout_r       <= cfg_wdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming tick; an empty slot is loaded when no word arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_echo_r <= in_echo_level;
    end
  end

  upr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .echo          (s1_echo_r),
    .ping_interval (ping_interval_r),
    .trigger_width (trig_width_r),
    .echo_timeout  (timeout_r),
    .trigger       (trigger),
    .meas          (meas)
  );

  upr_range u_range (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .meas         (meas),
    .threshold    (threshold_r),
    .report       (report),
    .distance_nxt (distance_nxt)
  );

  // Result register: valid follows the input slot, payload loads on a step
  // and holds while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_trig_r <= trigger;
      out_done_r <= meas.finish;
      out_tout_r <= meas.timed_out;
      out_rep_r  <= report;
      out_dist_r <= distance_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_trig_r;
  assign out_reading_done  = out_done_r;
  assign out_timed_out     = out_tout_r;
  assign out_report_valid  = out_rep_r;
  assign out_distance_in   = out_dist_r;

  // A report only comes with a completed reading.
  `UPR_ASSERT_NOW(a_report_needs_done, out_valid_r && out_rep_r, out_done_r)
  // A timeout only comes with a completed reading.
  `UPR_ASSERT_NOW(a_timeout_needs_done, out_valid_r && out_tout_r, out_done_r)
  // A reported timeout always stores zero inches.
  `UPR_ASSERT_NOW(a_timeout_zero_dist, out_valid_r && out_tout_r && out_rep_r,
                  out_dist_r == '0)
  // A processed tick always shows up as a result word.
  `UPR_ASSERT_NEXT(a_step_gives_word, step, out_valid_r)

endmodule
`default_nettype wire
